@@ src/aaps_pkg.sv @@
// Shared types and constants for the audio activity power switch.
`default_nettype none
package aaps_pkg;

    localparam int ADC_BITS    = 10;
    localparam int VALUE_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int TIMER_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Mid level of the LED reading, wide enough for converter widths up to 17 bits.
    localparam int                 LEVEL_CMP_W = 17;
    localparam logic [LEVEL_CMP_W-1:0] LED_MID =
        LEVEL_CMP_W'(1) << (ADC_BITS - 1);
    localparam logic [VALUE_W-1:0] ADC_MASK =
        VALUE_W'((32'd1 << ADC_BITS) - 32'd1);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [VALUE_W-1:0] THRESHOLD_RESET = 10'd512;
    localparam logic [COUNT_W-1:0] REQUIRED_RESET  = 11'd1;
    localparam logic [TIMER_W-1:0] HOLD_RESET      = 16'd60;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_AUDIO_THRESHOLD = 2'd0,
        REG_REQUIRED_COUNT  = 2'd1,
        REG_HOLD_WINDOWS    = 2'd2
    } reg_index_t;

    typedef enum logic {
        KIND_AUDIO = 1'b0,
        KIND_LED   = 1'b1
    } sample_kind_t;

    typedef struct packed {
        logic               sample_kind;
        logic [VALUE_W-1:0] adc_value;
    } sample_item_t;

    typedef struct packed {
        logic activity_led;
        logic toggle_request;
    } result_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] audio_threshold;
        logic [COUNT_W-1:0] required_count;
        logic [TIMER_W-1:0] hold_windows;
    } cfg_t;

endpackage
`default_nettype wire

@@ src/audio_activity_power_switch.sv @@
// Audio activity power switch: two-stage request pipeline around the window logic.
//
// Each request (an audio sample or an LED level reading) yields exactly one
// result. Requests are taken one per cycle unless sample_stall is high: a
// request lands in an input register, and the window logic then evaluates it
// against the stored state and writes the result register. The input
// register keeps accepting while a result waits to be taken; the path stalls
// only when both stages hold data and the result side stalls. Configuration
// writes take effect at the next clock and are meant to be made while no
// request is in flight.
`default_nettype none
module audio_activity_power_switch (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              sample_valid,
    output logic                                   sample_stall,
    input  aaps_pkg::sample_item_t                 sample,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output aaps_pkg::result_item_t                 result,
    input  wire logic                              write_enable,
    input  wire logic [aaps_pkg::CFG_INDEX_W-1:0]  reg_index,
    input  wire logic [aaps_pkg::CFG_DATA_W-1:0]   write_data
);
    import aaps_pkg::*;

    cfg_t         cfg;
    sample_item_t in_item_reg;
    logic         in_valid_reg, in_valid_next;
    result_item_t out_item_reg;
    result_item_t core_result;
    logic         out_valid_reg, out_valid_next;
    logic         advance;
    logic         take;

    aaps_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .cfg          (cfg)
    );

    aaps_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    assign advance      = in_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = in_valid_reg && !advance;
    assign take         = sample_valid && !sample_stall;

    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_item_reg <= sample;
        if (advance)
            out_item_reg <= core_result;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule
`default_nettype wire

@@ src/aaps_cfg_regs.sv @@
// Configuration register file for the audio activity power switch.
`default_nettype none
module aaps_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              write_enable,
    input  wire logic [aaps_pkg::CFG_INDEX_W-1:0]  reg_index,
    input  wire logic [aaps_pkg::CFG_DATA_W-1:0]   write_data,
    output aaps_pkg::cfg_t                         cfg
);
    import aaps_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_enable)
        begin
            unique case (reg_index)
                REG_AUDIO_THRESHOLD: cfg_next.audio_threshold = write_data[VALUE_W-1:0];
                REG_REQUIRED_COUNT:  cfg_next.required_count  = write_data[COUNT_W-1:0];
                REG_HOLD_WINDOWS:    cfg_next.hold_windows    = write_data[TIMER_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.audio_threshold <= THRESHOLD_RESET;
            cfg_reg.required_count  <= REQUIRED_RESET;
            cfg_reg.hold_windows    <= HOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ src/aaps_core.sv @@
// Window state and per-sample decision logic.
`default_nettype none
module aaps_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  aaps_pkg::sample_item_t    item,
    input  aaps_pkg::cfg_t            cfg,
    output aaps_pkg::result_item_t    result
);
    import aaps_pkg::*;

    logic [COUNT_W-1:0] active_count_reg, active_count_next;
    logic [VALUE_W-1:0] prev_level_reg, prev_level_next;
    logic [TIMER_W-1:0] idle_timer_reg, idle_timer_next;
    logic [TIMER_W-1:0] lockout_reg, lockout_next;

    logic [VALUE_W-1:0] level;
    logic               active;
    logic               was_on;
    logic               is_on;
    logic               off_edge;
    logic               on_edge;
    logic               meets;
    logic [TIMER_W-1:0] lock_mid;
    logic [TIMER_W-1:0] idle_mid;

    assign level    = item.adc_value & ADC_MASK;
    assign active   = level > cfg.audio_threshold;
    assign was_on   = LEVEL_CMP_W'(prev_level_reg) > LED_MID;
    assign is_on    = LEVEL_CMP_W'(level) > LED_MID;
    assign off_edge = was_on && !is_on && (idle_timer_reg != '0);
    assign on_edge  = !was_on && is_on;
    assign lock_mid = (off_edge || on_edge) ? cfg.hold_windows : lockout_reg;
    assign idle_mid = off_edge ? '0 : idle_timer_reg;

    always_comb
    begin
        priority if (on_edge)
            meets = 1'b1;
        else if (off_edge)
            meets = (cfg.required_count == '0);
        else
            meets = (active_count_reg >= cfg.required_count);
    end

    always_comb
    begin
        active_count_next = active_count_reg;
        prev_level_next   = prev_level_reg;
        idle_timer_next   = idle_timer_reg;
        lockout_next      = lockout_reg;
        result            = '0;
        if (item.sample_kind == KIND_AUDIO)
        begin
            result.activity_led = active;
            if (active && (active_count_reg != COUNT_MAX))
                active_count_next = active_count_reg + COUNT_W'(1);
        end
        else
        begin
            active_count_next = '0;
            prev_level_next   = level;
            idle_timer_next   = idle_mid;
            if (lock_mid != '0)
            begin
                lockout_next = lock_mid - TIMER_W'(1);
            end
            else
            begin
                lockout_next = '0;
                if (is_on)
                begin
                    priority if (meets)
                        idle_timer_next = cfg.hold_windows;
                    else if (idle_mid <= TIMER_W'(1))
                    begin
                        idle_timer_next       = '0;
                        result.toggle_request = 1'b1;
                    end
                    else
                        idle_timer_next = idle_mid - TIMER_W'(1);
                end
                else if (meets)
                begin
                    idle_timer_next       = cfg.hold_windows;
                    result.toggle_request = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_count_reg <= '0;
            prev_level_reg   <= '0;
            idle_timer_reg   <= '0;
            lockout_reg      <= '0;
        end
        else if (advance)
        begin
            active_count_reg <= active_count_next;
            prev_level_reg   <= prev_level_next;
            idle_timer_reg   <= idle_timer_next;
            lockout_reg      <= lockout_next;
        end
    end

endmodule
`default_nettype wire
